// ----- rtl/frc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants of the framed upload receiver
// Transaction payloads, configuration set, phase and status codes, and the
// running checksum step.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int unsigned LenW    = 24;
  localparam int unsigned SumW    = 32;
  localparam int unsigned TickW   = 16;
  localparam int unsigned AddrW   = 18;
  localparam int unsigned SizeW   = 19;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  localparam logic [7:0]      StartMark = 8'h02;
  localparam logic [7:0]      EndMark   = 8'h03;
  localparam logic [SumW-1:0] SumPoly   = 32'h1d87_2b41;
  localparam logic [SumW-1:0] SumInit   = 32'h0000_0001;
  localparam logic [TickW-1:0] TimeoutReset = 16'd1000;

  typedef enum logic [1:0] {
    KindStart = 2'd0,
    KindByte  = 2'd1,
    KindTick  = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhWaitStx = 2'd1,
    PhData    = 2'd2,
    PhWaitEtx = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    StBusy     = 3'd0,
    StOk       = 3'd1,
    StFail     = 3'd2,
    StTimeout  = 3'd3,
    StTooLarge = 3'd4,
    StIdle     = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageLength = 2'd0,
    RegExpectedSum = 2'd1,
    RegTimeout     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] write_address;
    logic [7:0]       write_data;
    logic [2:0]       status;
    logic [SumW-1:0]  running_sum;
    logic [SizeW-1:0] loaded_size;
  } out_t;

  typedef struct packed {
    logic [LenW-1:0]  image_length;
    logic [SumW-1:0]  expected_checksum;
    logic [TickW-1:0] timeout_limit;
  } cfg_t;

  function automatic logic [SumW-1:0] fold_byte(logic [SumW-1:0] s, logic [7:0] b);
    logic [SumW-1:0] n;
    n = {s[SumW-2:0], 1'b0};
    if (s[SumW-1]) begin
      n = n ^ SumPoly;
    end
    return n ^ {{(SumW-8){1'b0}}, b};
  endfunction

endpackage

// ----- rtl/framed_upload_receiver_checksum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_upload_receiver_checksum: STX/ETX framed upload receiver
// Takes start, byte and tick transactions; issues image stores, keeps the
// running checksum, and reports busy, ok, fail, timeout, too large or idle.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+-------------------------------
//   in      | in  | in_valid_i / in_ready_o | in_data_i   (frc_pkg::in_t)
//   out     | out | out_valid_o/ out_ready_i| out_data_o  (frc_pkg::out_t)
//   cfg     | in  | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// One transaction per cycle while the result is not stalled; a transaction is
// first captured in the input register, then goes through a single
// combinational update into the result register. Reset clears the phase,
// counters and valid flags at once; timeout_limit resets to 1000. With the
// result stalled, one more input is held in the input register before
// in_ready_o drops. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module framed_upload_receiver_checksum #(
  parameter int unsigned MAX_IMAGE_BYTES = 262144
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  frc_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output frc_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [frc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [frc_pkg::CfgDatW-1:0] cfg_data_i
);

  localparam int unsigned CmpW = frc_pkg::LenW + 1;
  localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_IMAGE_BYTES);

  frc_pkg::cfg_t   cfg;
  frc_pkg::in_t    in_q;
  logic            in_valid_q;
  frc_pkg::out_t   out_q, out_d;
  logic            out_valid_q;
  logic            advance;

  frc_pkg::phase_e                phase_q, phase_d;
  logic [frc_pkg::LenW-1:0]       count_q, count_d;
  logic [frc_pkg::TickW-1:0]      ticks_q, ticks_d;
  logic [frc_pkg::SumW-1:0]       sum_q, sum_d;
  logic [frc_pkg::SizeW-1:0]      size_q, size_d;
  logic                           done;
  frc_pkg::status_e               done_status;

  logic [frc_pkg::LenW-1:0]  count_inc;
  logic [frc_pkg::TickW:0]   ticks_inc;
  logic                      too_large;
  frc_pkg::kind_e            kind;

  frc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign kind      = frc_pkg::kind_e'(in_q.kind);
  assign count_inc = count_q + 1'b1;
  assign ticks_inc = {1'b0, ticks_q} + 1'b1;
  assign too_large = {1'b0, cfg.image_length} > MaxLen;

  // next state
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    ticks_d     = ticks_q;
    sum_d       = sum_q;
    size_d      = size_q;
    done        = 1'b0;
    done_status = frc_pkg::StBusy;
    case (kind)
      frc_pkg::KindStart: begin
        size_d = '0;
        if (too_large) begin
          phase_d     = frc_pkg::PhIdle;
          done        = 1'b1;
          done_status = frc_pkg::StTooLarge;
        end else begin
          phase_d = frc_pkg::PhWaitStx;
          count_d = '0;
          ticks_d = '0;
          sum_d   = frc_pkg::SumInit;
        end
      end
      frc_pkg::KindByte: begin
        case (phase_q)
          frc_pkg::PhWaitStx: begin
            if (in_q.rx_byte == frc_pkg::StartMark) begin
              ticks_d = '0;
              phase_d = (cfg.image_length == '0) ? frc_pkg::PhWaitEtx : frc_pkg::PhData;
            end
          end
          frc_pkg::PhData: begin
            sum_d   = frc_pkg::fold_byte(sum_q, in_q.rx_byte);
            count_d = count_inc;
            ticks_d = '0;
            if (count_inc >= cfg.image_length) begin
              phase_d = frc_pkg::PhWaitEtx;
            end
          end
          frc_pkg::PhWaitEtx: begin
            if (in_q.rx_byte == frc_pkg::EndMark) begin
              done    = 1'b1;
              phase_d = frc_pkg::PhIdle;
              if (sum_q == cfg.expected_checksum) begin
                size_d      = cfg.image_length[frc_pkg::SizeW-1:0];
                done_status = frc_pkg::StOk;
              end else begin
                done_status = frc_pkg::StFail;
              end
            end
          end
          default: ;
        endcase
      end
      frc_pkg::KindTick: begin
        if (phase_q != frc_pkg::PhIdle) begin
          if (ticks_inc > {1'b0, cfg.timeout_limit}) begin
            phase_d     = frc_pkg::PhIdle;
            done        = 1'b1;
            done_status = frc_pkg::StTimeout;
          end else begin
            ticks_d = ticks_inc[frc_pkg::TickW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    out_d.write_enable  = 1'b0;
    out_d.write_address = '0;
    out_d.write_data    = '0;
    if (kind == frc_pkg::KindByte && phase_q == frc_pkg::PhData) begin
      out_d.write_enable  = 1'b1;
      out_d.write_address = count_q[frc_pkg::AddrW-1:0];
      out_d.write_data    = in_q.rx_byte;
    end
    if (done) begin
      out_d.status = done_status;
    end else if (phase_d == frc_pkg::PhIdle) begin
      out_d.status = frc_pkg::StIdle;
    end else begin
      out_d.status = frc_pkg::StBusy;
    end
    out_d.running_sum = sum_d;
    out_d.loaded_size = size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= frc_pkg::PhIdle;
      count_q     <= '0;
      ticks_q     <= '0;
      sum_q       <= frc_pkg::SumInit;
      size_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        count_q     <= count_d;
        ticks_q     <= ticks_d;
        sum_q       <= sum_d;
        size_q      <= size_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  a_store_is_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.write_enable |-> out_q.status == frc_pkg::StBusy)
    else $error("store reported with a final status");

  a_size_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.loaded_size != '0 |->
      out_q.status == frc_pkg::StOk || out_q.status == frc_pkg::StIdle)
    else $error("loaded size shown outside success or idle");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  a_advance_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed transaction lost its result");

endmodule

// ----- rtl/frc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_cfg_regs: configuration register file
// Holds image length, expected checksum and timeout limit; one write
// transaction per cycle, unknown indexes dropped.
// ----------------------------------------------------------------------------
module frc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [frc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [frc_pkg::CfgDatW-1:0] cfg_data_i,
  output frc_pkg::cfg_t               cfg_o
);

  frc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (frc_pkg::cfg_reg_e'(cfg_index_i))
        frc_pkg::RegImageLength: cfg_d.image_length = cfg_data_i[frc_pkg::LenW-1:0];
        frc_pkg::RegExpectedSum: cfg_d.expected_checksum = cfg_data_i[frc_pkg::SumW-1:0];
        frc_pkg::RegTimeout:     cfg_d.timeout_limit = cfg_data_i[frc_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_length      <= '0;
      cfg_q.expected_checksum <= '0;
      cfg_q.timeout_limit     <= frc_pkg::TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
